// ===== rtl/ipdata_frame_receiver_defines.svh =====
// assertion helpers for the ipdata frame receiver
`ifndef IPDATA_FRAME_RECEIVER_DEFINES_SVH
`define IPDATA_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, off while reset is low
`define IFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define IFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifr_pkg.sv =====
package ifr_pkg;

    localparam int HDR_LEN = 8;
    localparam int HM_W    = 3;
    localparam int LEN_W   = 10;
    localparam int DIG_W   = 2;
    localparam int HEX_W   = 11;
    localparam int TMO_W   = 14;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] HEX_UC_OFS = 8'h37;
    localparam logic [7:0] HEX_LC_OFS = 8'h57;

    localparam logic [TMO_W-1:0] TMO_MIN = TMO_W'(10);
    localparam logic [DIG_W-1:0] MAX_DIGITS = DIG_W'(3);

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_QUOTE = 3'd2,
        PH_DATA  = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_LENGTH  = 2'd1,
        CAUSE_FORMAT  = 2'd2,
        CAUSE_TIMEOUT = 2'd3
    } t_cause;

    // one registered input beat handed to the deframer
    typedef struct packed {
        logic       valid;
        t_op        op;
        logic [7:0] rx_byte;
    } t_item;

    function automatic logic [7:0] hdr_char(input logic [HM_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h25; // %
            3'd1:    ch = 8'h49; // I
            3'd2:    ch = 8'h50; // P
            3'd3:    ch = 8'h44; // D
            3'd4:    ch = 8'h41; // A
            3'd5:    ch = 8'h54; // T
            3'd6:    ch = 8'h41; // A
            3'd7:    ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] v;
        d = 8'h00;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            v = {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - HEX_UC_OFS;
            v = {1'b0, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - HEX_LC_OFS;
            v = {1'b0, d[3:0]};
        end
        return v;
    endfunction

endpackage

// ===== rtl/ifr_stream_if.sv =====
interface ifr_in_if;
    import ifr_pkg::*;

    logic       valid;
    logic       ready;
    t_op        opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ifr_out_if;
    import ifr_pkg::*;

    logic             valid;
    logic             ready;
    t_kind            result_kind;
    logic [7:0]       payload_byte;
    t_cause           reject_cause;
    logic [LEN_W-1:0] declared_length;
    logic             is_last;

    modport source (output valid, output result_kind, output payload_byte,
                    output reject_cause, output declared_length, output is_last,
                    input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input reject_cause, input declared_length, input is_last,
                    output ready);
endinterface

// ===== rtl/ifr_in_stage.sv =====
module ifr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifr_in_if.sink        i_in,
    input  logic          i_take,
    output ifr_pkg::t_item o_item
);
    import ifr_pkg::*;

    logic       r_valid;
    t_op        r_op;
    logic [7:0] r_byte;
    logic       n_valid;

    // stage frees up when the deframer takes the beat
    assign i_in.ready = !r_valid || i_take;
    assign n_valid    = i_in.ready ? i_in.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.opcode;
            r_byte <= i_in.rx_byte;
        end
    end

    assign o_item = '{valid: r_valid, op: r_op, rx_byte: r_byte};

endmodule

// ===== rtl/ifr_deframer.sv =====
module ifr_deframer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ifr_pkg::t_item i_item,
    output logic           o_take,
    ifr_out_if.source      o_out
);
    import ifr_pkg::*;

    t_phase            r_phase,  n_phase;
    logic [HM_W-1:0]   r_hm,     n_hm;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [DIG_W-1:0]  r_dig,    n_dig;
    logic [HEX_W-1:0]  r_hex,    n_hex;
    logic [3:0]        r_held,   n_held;
    logic [TMO_W-1:0]  r_tmo,    n_tmo;

    logic              r_out_valid, n_out_valid;
    t_kind             r_kind;
    logic [7:0]        r_pbyte;
    t_cause            r_cause;
    logic [LEN_W-1:0]  r_dlen;
    logic              r_last;

    logic              res_valid;
    t_kind             res_kind;
    logic [7:0]        res_byte;
    t_cause            res_cause;
    logic              verdict;
    logic              accept;
    t_cause            vcause;

    logic [7:0]        c;
    logic              is_digit;
    logic [4:0]        hexv;
    logic [TMO_W-1:0]  len_x10;
    logic [TMO_W-1:0]  tmo_dec;
    logic [HEX_W-1:0]  hex_lim;
    logic [HEX_W-1:0]  hex_inc;

    assign o_take = i_item.valid && (!r_out_valid || o_out.ready);

    assign c        = i_item.rx_byte;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign hexv     = hex_value(c);
    assign len_x10  = TMO_W'({r_len, 3'b000}) + TMO_W'({r_len, 1'b0});
    assign tmo_dec  = (r_tmo != '0) ? r_tmo - TMO_W'(1) : '0;
    assign hex_lim  = {r_len, 1'b1};
    assign hex_inc  = r_hex + HEX_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_hm      = r_hm;
        n_len     = r_len;
        n_dig     = r_dig;
        n_hex     = r_hex;
        n_held    = r_held;
        n_tmo     = r_tmo;
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_byte  = 8'h00;
        res_cause = CAUSE_NONE;
        verdict   = 1'b0;
        accept    = 1'b0;
        vcause    = CAUSE_NONE;

        if (i_item.op == OP_TICK) begin
            if (r_phase == PH_QUOTE || r_phase == PH_DATA) begin
                if (tmo_dec < TMO_MIN) begin
                    verdict = 1'b1;
                    vcause  = CAUSE_TIMEOUT;
                end else begin
                    n_tmo = tmo_dec;
                end
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    if (is_digit) begin
                        if (r_dig >= MAX_DIGITS) begin
                            verdict = 1'b1;
                            vcause  = CAUSE_FORMAT;
                        end else begin
                            n_len = LEN_W'(len_x10 + TMO_W'(c[3:0]));
                            n_dig = r_dig + DIG_W'(1);
                        end
                    end else if (c == CH_COMMA && r_dig != '0 && r_len != '0) begin
                        n_phase = PH_QUOTE;
                        n_tmo   = len_x10;
                    end else begin
                        verdict = 1'b1;
                        vcause  = CAUSE_FORMAT;
                    end
                end
                PH_QUOTE: begin
                    if (c != CH_QUOTE) begin
                        verdict = 1'b1;
                        vcause  = CAUSE_FORMAT;
                    end else begin
                        n_phase = PH_DATA;
                        n_hex   = '0;
                        n_held  = '0;
                    end
                end
                PH_DATA: begin
                    if (c == CH_QUOTE) begin
                        verdict = 1'b1;
                        accept  = (r_hex[HEX_W-1:1] == r_len);
                        vcause  = CAUSE_LENGTH;
                    end else if (hexv[4]) begin
                        verdict = 1'b1;
                        vcause  = CAUSE_FORMAT;
                    end else if (r_hex >= hex_lim) begin
                        verdict = 1'b1;
                        vcause  = CAUSE_LENGTH;
                    end else begin
                        n_hex = hex_inc;
                        if (hex_inc[0]) begin
                            n_held = hexv[3:0];
                        end else begin
                            res_valid = 1'b1;
                            res_byte  = {r_held, hexv[3:0]};
                            n_held    = '0;
                        end
                    end
                end
                default: begin
                    // header hunt; a stray '%' restarts the match at one
                    if (c == hdr_char(r_hm)) begin
                        if (r_hm == HM_W'(HDR_LEN - 1)) begin
                            n_phase = PH_LEN;
                            n_hm    = '0;
                            n_len   = '0;
                            n_dig   = '0;
                        end else begin
                            n_hm = r_hm + HM_W'(1);
                        end
                    end else begin
                        n_hm = (c == CH_PERCENT) ? HM_W'(1) : '0;
                    end
                end
            endcase
        end

        if (verdict) begin
            res_valid = 1'b1;
            res_kind  = accept ? KIND_ACCEPT : KIND_REJECT;
            res_cause = accept ? CAUSE_NONE : vcause;
            n_phase   = PH_HUNT;
            n_hm      = '0;
            n_len     = '0;
            n_dig     = '0;
            n_hex     = '0;
            n_held    = '0;
            n_tmo     = '0;
        end
    end

    assign n_out_valid = o_take ? res_valid : (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_hm        <= '0;
            r_len       <= '0;
            r_dig       <= '0;
            r_hex       <= '0;
            r_held      <= '0;
            r_tmo       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase <= n_phase;
                r_hm    <= n_hm;
                r_len   <= n_len;
                r_dig   <= n_dig;
                r_hex   <= n_hex;
                r_held  <= n_held;
                r_tmo   <= n_tmo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && res_valid) begin
            r_kind  <= res_kind;
            r_pbyte <= res_byte;
            r_cause <= res_cause;
            r_dlen  <= r_len;
            r_last  <= verdict;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = r_kind;
    assign o_out.payload_byte    = r_pbyte;
    assign o_out.reject_cause    = r_cause;
    assign o_out.declared_length = r_dlen;
    assign o_out.is_last         = r_last;

endmodule

// ===== rtl/ipdata_frame_receiver.sv =====
// Deframes modem receive lines %IPDATA:<n>,"<hex>" from a byte stream.
// i_in carries one beat per received byte (opcode 0) or per 10 ms timer
// tick (opcode 1). o_out carries one beat per decoded payload byte and one
// verdict beat (accept or reject, is_last set) at the end of each frame.
// Payload beats leave before the verdict; a sink drops them on a reject.
// Many input beats give no output beat (header, length, ticks).
// An accepted input beat is registered in the input stage, then processed
// by the deframer into the output register before it shows on o_out.
// Throughput: one input beat per cycle while o_out does not stall; the
// parser state update is the logic between the input and output registers.
// When o_out stalls, the output register holds its beat, the input register
// fills, and i_in.ready drops only while both are occupied.
// Reset (synchronous, active low) empties both registers and returns the
// parser to header hunt with the timeout timer idle.
`include "ipdata_frame_receiver_defines.svh"

module ipdata_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ifr_in_if.sink     i_in,
    ifr_out_if.source  o_out
);
    import ifr_pkg::*;

    t_item w_item;
    logic  w_take;

    ifr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    ifr_deframer u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_out   (o_out)
    );

    `IFR_ASSERT_NOW(a_last_on_verdict, i_clk, i_rst_n, o_out.valid,
        o_out.is_last == (o_out.result_kind != KIND_PAYLOAD), "is_last mismatch")
    `IFR_ASSERT_NOW(a_clean_accept, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind != KIND_REJECT,
        o_out.reject_cause == CAUSE_NONE && o_out.declared_length != '0,
        "cause or length wrong on payload or accept")
    `IFR_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, !i_in.ready,
        w_item.valid && o_out.valid && !o_out.ready, "input stalled without backpressure")
    `IFR_ASSERT_NEXT(a_beat_captured, i_clk, i_rst_n, i_in.valid && i_in.ready,
        w_item.valid, "accepted beat lost")

endmodule
